>>> sv/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types and constants of the quaternion to euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   // component and product widths
   localparam int COMP_W   = 16;
   localparam int CFB      = 14;
   localparam int AFB      = 6;
   localparam int PROD_W   = 2 * COMP_W;
   localparam int SUM_W    = PROD_W + 3;
   localparam int ARG_W    = ((2 * CFB + 3) > SUM_W) ? (2 * CFB + 3) : SUM_W;
   localparam int CORDIC_W = ARG_W + 3;

   // pole test widths
   localparam int THRESH_W = 16;
   localparam int LIM_W    = THRESH_W + SUM_W + 2;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd32735;

   // asin argument and square root
   localparam int S30_W      = 32;
   localparam int SHIFT      = 2 * CFB - 30;
   localparam int SHIFT_R    = (SHIFT > 0) ? SHIFT : 0;
   localparam int SHIFT_L    = (SHIFT < 0) ? -SHIFT : 0;
   localparam int ROOT_W     = 61;
   localparam int ROOT_STEPS = 31;

   // binary angles and output units
   localparam int ANGLE_W = 32;
   localparam int UNIT_W  = 15;
   localparam int FULL_W  = 9 + AFB;
   localparam int UNIT_PROD_W = ((ANGLE_W + FULL_W) > (ANGLE_W + UNIT_W)) ?
                                (ANGLE_W + FULL_W) : (ANGLE_W + UNIT_W);
   localparam logic [FULL_W-1:0] FULL_TURN_UNITS = FULL_W'(360 << AFB);
   localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

   // request queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   // configuration registers
   localparam int ADDR_W = 3;
   localparam logic [0:0] REG_POLE_THRESHOLD = 1'b0;

   // atan(2^-i) in binary angle units
   localparam logic [ANGLE_W-1:0] ATAN_TABLE [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      POLE_NONE  = 2'd0,
      POLE_NORTH = 2'd1,
      POLE_SOUTH = 2'd2
   } pole_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      pole_type                  code;
      logic signed [ARG_W-1:0]   yaw_y;
      logic signed [ARG_W-1:0]   yaw_x;
      logic signed [ARG_W-1:0]   roll_y;
      logic signed [ARG_W-1:0]   roll_x;
      logic signed [S30_W-1:0]   s30;
   } entry_type;

endpackage

>>> sv/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Takes requests, forms the products, norm sum and pole test, and classifies.
// ----------------------------------------------------------------------------
module q2e_front import q2e_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic signed [COMP_W-1:0]   comp_x,
   input  logic signed [COMP_W-1:0]   comp_y,
   input  logic signed [COMP_W-1:0]   comp_z,
   input  logic signed [COMP_W-1:0]   comp_w,
   input  logic [THRESH_W-1:0]        pole_threshold,
   output logic                       push_valid,
   output entry_type                  push_entry,
   output logic [2:0]                 inflight
);

   localparam logic signed [ARG_W-1:0] ONE = ARG_W'(64'sd1 <<< (2 * CFB));

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;

   // stage 1: captured components
   logic signed [COMP_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff, s1_w_ff;

   // stage 2: products
   logic signed [PROD_W-1:0] p_xx_ff, p_yy_ff, p_zz_ff, p_ww_ff, p_xw_ff;
   logic signed [PROD_W-1:0] p_yz_ff, p_wy_ff, p_zx_ff, p_wz_ff, p_xy_ff;
   logic signed [COMP_W-1:0] s2_x_ff, s2_y_ff;

   // stage 3: sums
   logic signed [SUM_W-1:0] unit_in, unit_ff, test_in, test_ff;
   logic signed [ARG_W-1:0] yaw_y_in, yaw_x_in, roll_y_in, roll_x_in;
   logic signed [ARG_W-1:0] s3_yaw_y_ff, s3_yaw_x_ff, s3_roll_y_ff, s3_roll_x_ff;
   logic signed [COMP_W-1:0] s3_x_ff, s3_y_ff;

   // stage 4: scaled test, limit and asin argument
   logic signed [LIM_W-1:0] lim_in, lim_ff, scaled_in, scaled_ff;
   logic signed [ARG_W-1:0] s_full, s_clamp;
   logic signed [63:0]      s_wide;
   logic signed [S30_W-1:0] s30_in, s30_ff;
   logic signed [ARG_W-1:0] s4_yaw_y_ff, s4_yaw_x_ff, s4_roll_y_ff, s4_roll_x_ff;
   logic signed [COMP_W-1:0] s4_x_ff, s4_y_ff;

   logic north, south;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   assign inflight = 3'(s1_vld_ff) + 3'(s2_vld_ff) + 3'(s3_vld_ff) + 3'(s4_vld_ff);

   // stage 1 and 2 payload
   always_ff @(posedge clock) begin
      s1_x_ff <= comp_x;
      s1_y_ff <= comp_y;
      s1_z_ff <= comp_z;
      s1_w_ff <= comp_w;
      p_xx_ff <= s1_x_ff * s1_x_ff;
      p_yy_ff <= s1_y_ff * s1_y_ff;
      p_zz_ff <= s1_z_ff * s1_z_ff;
      p_ww_ff <= s1_w_ff * s1_w_ff;
      p_xw_ff <= s1_x_ff * s1_w_ff;
      p_yz_ff <= s1_y_ff * s1_z_ff;
      p_wy_ff <= s1_w_ff * s1_y_ff;
      p_zx_ff <= s1_z_ff * s1_x_ff;
      p_wz_ff <= s1_w_ff * s1_z_ff;
      p_xy_ff <= s1_x_ff * s1_y_ff;
      s2_x_ff <= s1_x_ff;
      s2_y_ff <= s1_y_ff;
   end

   // norm sum, pole test and atan2 arguments
   always_comb begin
      unit_in   = SUM_W'(p_xx_ff) + SUM_W'(p_yy_ff) + SUM_W'(p_zz_ff) + SUM_W'(p_ww_ff);
      test_in   = SUM_W'(p_xw_ff) - SUM_W'(p_yz_ff);
      yaw_y_in  = (ARG_W'(p_wy_ff) + ARG_W'(p_zx_ff)) <<< 1;
      yaw_x_in  = ONE - ((ARG_W'(p_xx_ff) + ARG_W'(p_yy_ff)) <<< 1);
      roll_y_in = (ARG_W'(p_wz_ff) + ARG_W'(p_xy_ff)) <<< 1;
      roll_x_in = ONE - ((ARG_W'(p_zz_ff) + ARG_W'(p_xx_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      unit_ff      <= unit_in;
      test_ff      <= test_in;
      s3_yaw_y_ff  <= yaw_y_in;
      s3_yaw_x_ff  <= yaw_x_in;
      s3_roll_y_ff <= roll_y_in;
      s3_roll_x_ff <= roll_x_in;
      s3_x_ff      <= s2_x_ff;
      s3_y_ff      <= s2_y_ff;
   end

   // threshold product, and asin argument saturated and brought to 30 fraction bits
   always_comb begin
      lim_in    = $signed({1'b0, pole_threshold}) * unit_ff;
      scaled_in = LIM_W'(test_ff) <<< 16;
      s_full    = ARG_W'(test_ff) <<< 1;
      if (s_full > ONE) begin
         s_clamp = ONE;
      end else if (s_full < -ONE) begin
         s_clamp = -ONE;
      end else begin
         s_clamp = s_full;
      end
      s_wide = (64'(s_clamp) >>> SHIFT_R) <<< SHIFT_L;
      s30_in = s_wide[S30_W-1:0];
   end

   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      scaled_ff    <= scaled_in;
      s30_ff       <= s30_in;
      s4_yaw_y_ff  <= s3_yaw_y_ff;
      s4_yaw_x_ff  <= s3_yaw_x_ff;
      s4_roll_y_ff <= s3_roll_y_ff;
      s4_roll_x_ff <= s3_roll_x_ff;
      s4_x_ff      <= s3_x_ff;
      s4_y_ff      <= s3_y_ff;
   end

   // pole classification
   assign north = scaled_ff > lim_ff;
   assign south = scaled_ff < -lim_ff;

   always_comb begin
      push_entry.roll_y = s4_roll_y_ff;
      push_entry.roll_x = s4_roll_x_ff;
      push_entry.s30    = s30_ff;
      if (north || south) begin
         push_entry.code  = north ? POLE_NORTH : POLE_SOUTH;
         push_entry.yaw_y = ARG_W'(s4_y_ff);
         push_entry.yaw_x = ARG_W'(s4_x_ff);
      end else begin
         push_entry.code  = POLE_NONE;
         push_entry.yaw_y = s4_yaw_y_ff;
         push_entry.yaw_x = s4_yaw_x_ff;
      end
   end

   assign push_valid = s4_vld_ff;

endmodule

>>> sv/q2e_queue.sv
// ----------------------------------------------------------------------------
// q2e_queue
// Small first-in first-out queue between the classifier and the angle datapath.
// ----------------------------------------------------------------------------
module q2e_queue import q2e_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  entry_type          push_entry,
   input  logic               pop,
   output logic               pop_valid,
   output entry_type          pop_entry,
   output logic [QCNT_W-1:0]  count
);

   entry_type             mem_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < QCNT_W'(QUEUE_DEPTH)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("queue underflow");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("count slip");
`endif

endmodule

>>> sv/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring cordic giving the binary angle of a vector.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                       clock,
   input  logic signed [CORDIC_W-1:0] vec_y,
   input  logic signed [CORDIC_W-1:0] vec_x,
   output logic [ANGLE_W-1:0]         angle
);

   localparam int N_IT = (ITERATIONS < 32) ? ITERATIONS : 32;

   logic signed [CORDIC_W-1:0] x_ff [0:N_IT];
   logic signed [CORDIC_W-1:0] y_ff [0:N_IT];
   logic [ANGLE_W-1:0]         ang_ff [0:N_IT];
   logic                       zero_ff [0:N_IT];
   logic signed [CORDIC_W-1:0] dx [0:N_IT-1];
   logic signed [CORDIC_W-1:0] dy [0:N_IT-1];

   // left half plane folded over by half a turn
   always_ff @(posedge clock) begin
      zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
      if (vec_x < 0) begin
         x_ff[0]   <= -vec_x;
         y_ff[0]   <= -vec_y;
         ang_ff[0] <= HALF_TURN;
      end else begin
         x_ff[0]   <= vec_x;
         y_ff[0]   <= vec_y;
         ang_ff[0] <= '0;
      end
   end

   // shifted terms of each stage
   always_comb begin
      for (int i = 0; i < N_IT; i++) begin
         dx[i] = y_ff[i] >>> i;
         dy[i] = x_ff[i] >>> i;
      end
   end

   // one micro-rotation per stage toward y = 0
   always_ff @(posedge clock) begin
      for (int i = 0; i < N_IT; i++) begin
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][CORDIC_W-1]) begin
            x_ff[i+1]   <= x_ff[i] + dx[i];
            y_ff[i+1]   <= y_ff[i] - dy[i];
            ang_ff[i+1] <= ang_ff[i] + ATAN_TABLE[i];
         end else begin
            x_ff[i+1]   <= x_ff[i] - dx[i];
            y_ff[i+1]   <= y_ff[i] + dy[i];
            ang_ff[i+1] <= ang_ff[i] - ATAN_TABLE[i];
         end
      end
   end

   assign angle = zero_ff[N_IT] ? '0 : ang_ff[N_IT];

endmodule

>>> sv/q2e_back.sv
// ----------------------------------------------------------------------------
// q2e_back
// Angle datapath: asin cosine root, three cordics, pole fix-up and scaling.
// ----------------------------------------------------------------------------
module q2e_back import q2e_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               entry_valid,
   input  entry_type          entry,
   output logic               rsp_valid,
   output logic [UNIT_W-1:0]  rsp_pitch_deg,
   output logic [UNIT_W-1:0]  rsp_yaw_deg,
   output logic [UNIT_W-1:0]  rsp_roll_deg,
   output logic [1:0]         rsp_pole_case
);

   localparam int N_IT  = (ITERATIONS < 32) ? ITERATIONS : 32;
   localparam int VLD_N = 6 + ROOT_STEPS + N_IT;

   logic [VLD_N-1:0] vld_ff;

   entry_type                b0_ff, b1_ff;
   logic signed [63:0]       sq_prod;
   logic [ROOT_W-1:0]        sq_ff;

   logic [ROOT_W-1:0] root_v_ff [0:ROOT_STEPS];
   logic [ROOT_W-1:0] root_r_ff [0:ROOT_STEPS];
   entry_type         side_ff   [0:ROOT_STEPS];
   logic [ROOT_W-1:0] root_v_in [0:ROOT_STEPS-1];
   logic [ROOT_W-1:0] root_r_in [0:ROOT_STEPS-1];
   logic [ROOT_W-1:0] trial     [0:ROOT_STEPS-1];
   logic [ROOT_W-1:0] bit_val   [0:ROOT_STEPS-1];

   logic signed [CORDIC_W-1:0] pitch_y, pitch_x, yaw_y, yaw_x, roll_y, roll_x;
   logic [ANGLE_W-1:0] pitch_c, yaw_c, roll_c;
   pole_type           code_ff [0:N_IT];

   logic [ANGLE_W-1:0] pitch_a_in, yaw_a_in, roll_a_in;
   logic [ANGLE_W-1:0] pitch_a_ff, yaw_a_ff, roll_a_ff;
   pole_type           code_a_ff;

   logic [UNIT_PROD_W-1:0] pitch_u, yaw_u, roll_u;

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[VLD_N-2:0], entry_valid};
      end
   end

   // square of the asin argument, then one minus it
   assign sq_prod = b0_ff.s30 * b0_ff.s30;

   always_ff @(posedge clock) begin
      b0_ff        <= entry;
      b1_ff        <= b0_ff;
      sq_ff        <= sq_prod[ROOT_W-1:0];
      root_v_ff[0] <= (ROOT_W'(1) << (ROOT_W - 1)) - sq_ff;
      root_r_ff[0] <= '0;
      side_ff[0]   <= b1_ff;
   end

   // restoring square root, one result bit per stage
   always_comb begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         bit_val[k] = ROOT_W'(1) << (ROOT_W - 1 - 2 * k);
         trial[k]   = root_r_ff[k] + bit_val[k];
         if (root_v_ff[k] >= trial[k]) begin
            root_v_in[k] = root_v_ff[k] - trial[k];
            root_r_in[k] = (root_r_ff[k] >> 1) + bit_val[k];
         end else begin
            root_v_in[k] = root_v_ff[k];
            root_r_in[k] = root_r_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         root_v_ff[k+1] <= root_v_in[k];
         root_r_ff[k+1] <= root_r_in[k];
         side_ff[k+1]   <= side_ff[k];
      end
   end

   // cordic operands
   assign pitch_y = CORDIC_W'(side_ff[ROOT_STEPS].s30);
   assign pitch_x = CORDIC_W'(root_r_ff[ROOT_STEPS]);
   assign yaw_y   = CORDIC_W'(side_ff[ROOT_STEPS].yaw_y);
   assign yaw_x   = CORDIC_W'(side_ff[ROOT_STEPS].yaw_x);
   assign roll_y  = CORDIC_W'(side_ff[ROOT_STEPS].roll_y);
   assign roll_x  = CORDIC_W'(side_ff[ROOT_STEPS].roll_x);

   q2e_cordic #(.ITERATIONS(ITERATIONS)) u_pitch (
      .clock (clock),
      .vec_y (pitch_y),
      .vec_x (pitch_x),
      .angle (pitch_c)
   );

   q2e_cordic #(.ITERATIONS(ITERATIONS)) u_yaw (
      .clock (clock),
      .vec_y (yaw_y),
      .vec_x (yaw_x),
      .angle (yaw_c)
   );

   q2e_cordic #(.ITERATIONS(ITERATIONS)) u_roll (
      .clock (clock),
      .vec_y (roll_y),
      .vec_x (roll_x),
      .angle (roll_c)
   );

   // pole code alongside the cordics
   always_ff @(posedge clock) begin
      code_ff[0] <= side_ff[ROOT_STEPS].code;
      for (int i = 0; i < N_IT; i++) begin
         code_ff[i+1] <= code_ff[i];
      end
   end

   // pole fix-up
   always_comb begin
      unique case (code_ff[N_IT])
         POLE_NORTH: begin
            pitch_a_in = QUARTER_TURN;
            yaw_a_in   = yaw_c << 1;
            roll_a_in  = '0;
         end
         POLE_SOUTH: begin
            pitch_a_in = QUARTER_TURN + HALF_TURN;
            yaw_a_in   = '0 - (yaw_c << 1);
            roll_a_in  = '0;
         end
         default: begin
            pitch_a_in = pitch_c;
            yaw_a_in   = yaw_c;
            roll_a_in  = roll_c;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pitch_a_ff <= pitch_a_in;
      yaw_a_ff   <= yaw_a_in;
      roll_a_ff  <= roll_a_in;
      code_a_ff  <= code_ff[N_IT];
   end

   // binary angle to 1/64 degree units, rounding half up
   assign pitch_u = UNIT_PROD_W'(pitch_a_ff) * UNIT_PROD_W'(FULL_TURN_UNITS)
                    + UNIT_PROD_W'(HALF_TURN);
   assign yaw_u   = UNIT_PROD_W'(yaw_a_ff) * UNIT_PROD_W'(FULL_TURN_UNITS)
                    + UNIT_PROD_W'(HALF_TURN);
   assign roll_u  = UNIT_PROD_W'(roll_a_ff) * UNIT_PROD_W'(FULL_TURN_UNITS)
                    + UNIT_PROD_W'(HALF_TURN);

   always_ff @(posedge clock) begin
      rsp_pitch_deg <= pitch_u[ANGLE_W +: UNIT_W];
      rsp_yaw_deg   <= yaw_u[ANGLE_W +: UNIT_W];
      rsp_roll_deg  <= roll_u[ANGLE_W +: UNIT_W];
      rsp_pole_case <= code_a_ff;
   end

   assign rsp_valid = vld_ff[VLD_N-1];

endmodule

>>> sv/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Quaternion to pitch, yaw and roll in 1/64 degree units, with pole detection.
// ----------------------------------------------------------------------------
// The block takes one request per clock whenever busy is low and returns one
// result per request, in order. Each request passes through four classifier
// stages, the queue, a 31-stage square root for the asin cosine, and the
// cordic pipeline of CORDIC_ITERATIONS stages. Results carry rsp_valid for one
// clock and cannot be held off, so the datapath never backs up and busy stays
// low in normal use. The user must write pole_threshold through the register
// port only while no request is in flight; the block does not enforce this.
module quaternion_to_euler_angles_top import q2e_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COMP_W-1:0]  req_comp_x,
   input  logic signed [COMP_W-1:0]  req_comp_y,
   input  logic signed [COMP_W-1:0]  req_comp_z,
   input  logic signed [COMP_W-1:0]  req_comp_w,
   output logic                      rsp_valid,
   output logic [UNIT_W-1:0]         rsp_pitch_deg,
   output logic [UNIT_W-1:0]         rsp_yaw_deg,
   output logic [UNIT_W-1:0]         rsp_roll_deg,
   output logic [1:0]                rsp_pole_case,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [THRESH_W-1:0] threshold_ff;
   logic                push_valid, pop_valid;
   entry_type           push_entry, pop_entry;
   logic [2:0]          inflight;
   logic [QCNT_W-1:0]   count;
   logic [QCNT_W:0]     occupancy;

   // register port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[ADDR_W-1 -: 1] == REG_POLE_THRESHOLD) begin
         threshold_ff <= pwdata[THRESH_W-1:0];
      end
   end

   assign prdata = (paddr[ADDR_W-1 -: 1] == REG_POLE_THRESHOLD) ?
                   32'(threshold_ff) : '0;

   // hold off requests when queue room may run short
   assign occupancy = (QCNT_W+1)'(count) + (QCNT_W+1)'(inflight);
   assign busy      = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);

   q2e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .comp_x         (req_comp_x),
      .comp_y         (req_comp_y),
      .comp_z         (req_comp_z),
      .comp_w         (req_comp_w),
      .pole_threshold (threshold_ff),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .inflight       (inflight)
   );

   q2e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop_valid),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .count      (count)
   );

   q2e_back #(.ITERATIONS(CORDIC_ITERATIONS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (pop_valid),
      .entry         (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_pitch_deg (rsp_pitch_deg),
      .rsp_yaw_deg   (rsp_yaw_deg),
      .rsp_roll_deg  (rsp_roll_deg),
      .rsp_pole_case (rsp_pole_case)
   );

`ifndef SYNTHESIS
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy) else $error("datapath backed up");
   a_take_tracked: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> inflight != 3'd0) else $error("request lost");
   a_north_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pole_case == POLE_NORTH |->
         rsp_pitch_deg == UNIT_W'(FULL_TURN_UNITS / 4) && rsp_roll_deg == '0)
      else $error("north pole angles wrong");
   a_south_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pole_case == POLE_SOUTH |->
         rsp_pitch_deg == UNIT_W'(3 * FULL_TURN_UNITS / 4) && rsp_roll_deg == '0)
      else $error("south pole angles wrong");
`endif

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the quaternion to euler angle converter. Requests
// go in through the start/busy port. A bit-exact angle predictor computes each
// result, and a checker compares it with the block's output in order. The pole
// threshold is swept through the register port between traffic phases.
// ----------------------------------------------------------------------------
module tb_top import q2e_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITERATIONS   = 16;
   localparam int SETTLE_CYC   = 80;
   localparam int STALL_LIMIT  = 3000;
   localparam logic [ADDR_W-1:0] THRESH_ADDR = ADDR_W'(4 * REG_POLE_THRESHOLD);
   localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

   typedef struct {
      logic [UNIT_W-1:0] pitch;
      logic [UNIT_W-1:0] yaw;
      logic [UNIT_W-1:0] roll;
      pole_type          pole;
   } angles_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [COMP_W-1:0]  req_comp_x = '0;
   logic signed [COMP_W-1:0]  req_comp_y = '0;
   logic signed [COMP_W-1:0]  req_comp_z = '0;
   logic signed [COMP_W-1:0]  req_comp_w = '0;
   logic                      rsp_valid;
   logic [UNIT_W-1:0]         rsp_pitch_deg;
   logic [UNIT_W-1:0]         rsp_yaw_deg;
   logic [UNIT_W-1:0]         rsp_roll_deg;
   logic [1:0]                rsp_pole_case;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [ADDR_W-1:0]         paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   angles_type          expected_angles[$];
   logic [THRESH_W-1:0] model_threshold;
   bit                idle_enable;
   bit                accepted_now;
   int                mismatches;
   int                stall_cycles;

   quaternion_to_euler_angles_top #(.CORDIC_ITERATIONS(ITERATIONS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_comp_x(req_comp_x), .req_comp_y(req_comp_y),
      .req_comp_z(req_comp_z), .req_comp_w(req_comp_w),
      .rsp_valid(rsp_valid), .rsp_pitch_deg(rsp_pitch_deg),
      .rsp_yaw_deg(rsp_yaw_deg), .rsp_roll_deg(rsp_roll_deg),
      .rsp_pole_case(rsp_pole_case),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // angle predictor
   // ------------------------------------------------------------------------

   // vectoring cordic, binary angle with 2^32 per turn
   function automatic logic [ANGLE_W-1:0] vector_angle(longint yv, longint xv);
      logic [ANGLE_W-1:0] ang;
      longint dx, dy;
      ang = '0;
      if (xv == 0 && yv == 0) return '0;
      if (xv < 0) begin
         xv = -xv;
         yv = -yv;
         ang = HALF_TURN;
      end
      for (int i = 0; i < ITERATIONS && i < 32; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv >= 0) begin
            xv = xv + dx;
            yv = yv - dy;
            ang = ang + ATAN_TABLE[i];
         end else begin
            xv = xv - dx;
            yv = yv + dy;
            ang = ang - ATAN_TABLE[i];
         end
      end
      return ang;
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // binary angle to 1/64 degree, round half up
   function automatic logic [UNIT_W-1:0] angle_units(logic [ANGLE_W-1:0] ang);
      logic [63:0] prod;
      prod = (64'(ang) * 64'(360 << AFB) + 64'h8000_0000) >> 32;
      return prod[UNIT_W-1:0];
   endfunction

   function automatic angles_type euler_of(logic signed [COMP_W-1:0] qx,
         logic signed [COMP_W-1:0] qy, logic signed [COMP_W-1:0] qz,
         logic signed [COMP_W-1:0] qw);
      longint x, y, z, w, one, norm, test, lim, scaled, s, s30;
      logic [ANGLE_W-1:0] pitch, yaw, roll;
      angles_type res;
      x = qx; y = qy; z = qz; w = qw;
      one = longint'(1) << (2 * CFB);
      norm = x * x + y * y + z * z + w * w;
      test = x * w - y * z;
      lim = longint'(model_threshold) * norm;
      scaled = test * 65536;
      if (scaled > lim) begin
         yaw = 2 * vector_angle(y, x);
         pitch = QUARTER_TURN;
         roll = '0;
         res.pole = POLE_NORTH;
      end else if (scaled < -lim) begin
         yaw = '0 - 2 * vector_angle(y, x);
         pitch = 3 * QUARTER_TURN;
         roll = '0;
         res.pole = POLE_SOUTH;
      end else begin
         yaw = vector_angle(2 * (w * y + z * x), one - 2 * (x * x + y * y));
         roll = vector_angle(2 * (w * z + x * y), one - 2 * (z * z + x * x));
         s = 2 * (w * x - y * z);
         if (s > one) s = one;
         if (s < -one) s = -one;
         // bring the sine to 30 fraction bits
         if (2 * CFB >= 30) s30 = s >>> (2 * CFB - 30);
         else s30 = s <<< (30 - 2 * CFB);
         pitch = vector_angle(s30,
            longint'(floor_root((64'd1 << 60) - 64'(s30 * s30))));
         res.pole = POLE_NONE;
      end
      res.pitch = angle_units(pitch);
      res.yaw = angle_units(yaw);
      res.roll = angle_units(roll);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------

   task automatic send_request(logic signed [COMP_W-1:0] qx,
         logic signed [COMP_W-1:0] qy, logic signed [COMP_W-1:0] qz,
         logic signed [COMP_W-1:0] qw);
      bit stalled;
      // occasional idle burst before the request
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_comp_x <= qx;
      req_comp_y <= qy;
      req_comp_z <= qz;
      req_comp_w <= qw;
      do begin
         @(negedge clock);
         stalled = busy;
         @(posedge clock);
      end while (stalled);
      accepted_now = 1'b1;
      expected_angles.push_back(euler_of(qx, qy, qz, qw));
   endtask

   task automatic end_stream();
      start <= 1'b0;
   endtask

   // random unit quaternion, optionally near a pole
   task automatic send_unit_request(bit near_pole);
      real c[4];
      real len;
      logic signed [COMP_W-1:0] q[4];
      for (int i = 0; i < 4; i++)
         c[i] = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      if (near_pole) begin
         // x close to plus or minus w, y and z small
         c[0] = 1.0;
         c[3] = ($urandom_range(0, 1) ? 1.0 : -1.0) *
                (1.0 + (real'($urandom_range(0, 200)) - 100.0) / 5000.0);
         c[1] = c[1] / 30.0;
         c[2] = c[2] / 30.0;
      end
      len = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      if (len < 1.0e-6) begin
         c[3] = 1.0;
         len = 1.0;
      end
      for (int i = 0; i < 4; i++)
         q[i] = COMP_W'($rtoi(c[i] / len * 16384.0));
      send_request(q[0], q[1], q[2], q[3]);
   endtask

   task automatic send_random_requests(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) send_unit_request(1'b0);
         else if (pick < 75) send_unit_request(1'b1);
         else if (pick < 85)
            send_request(COMP_W'($urandom_range(0, 32768) - 16384),
                         COMP_W'($urandom_range(0, 32768) - 16384),
                         COMP_W'($urandom_range(0, 32768) - 16384),
                         COMP_W'($urandom_range(0, 32768) - 16384));
         else
            send_request(COMP_W'($urandom), COMP_W'($urandom),
                         COMP_W'($urandom), COMP_W'($urandom));
      end
      end_stream();
   endtask

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------

   task automatic drain_requests();
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == THRESH_ADDR) model_threshold = data[THRESH_W-1:0];
   endtask

   task automatic csr_check_threshold();
      logic [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= THRESH_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got != 32'(model_threshold)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("threshold readback: expected %0d actual %0d",
                     model_threshold, got);
      end
   endtask

   task automatic set_threshold(logic [THRESH_W-1:0] value);
      drain_requests();
      csr_write(THRESH_ADDR, 32'(value));
      csr_check_threshold();
   endtask

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      angles_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with no request outstanding");
         end else begin
            exp_r = expected_angles.pop_front();
            if (rsp_pitch_deg !== exp_r.pitch || rsp_yaw_deg !== exp_r.yaw ||
                rsp_roll_deg !== exp_r.roll || rsp_pole_case !== exp_r.pole) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("angles: expected p=%0d y=%0d r=%0d c=%0d actual p=%0d y=%0d r=%0d c=%0d",
                           exp_r.pitch, exp_r.yaw, exp_r.roll, exp_r.pole,
                           rsp_pitch_deg, rsp_yaw_deg, rsp_roll_deg, rsp_pole_case);
            end
         end
      end
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if (reset || accepted_now || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      accepted_now = 1'b0;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_directed();
      send_request(0, 0, 0, 0);                    // zero quaternion
      send_request(0, 0, 0, 16384);                // identity
      send_request(0, 0, 0, -16384);
      send_request(16384, 0, 0, 0);
      send_request(-16384, 0, 0, 0);
      send_request(0, 16384, 0, 0);
      send_request(0, -16384, 0, 0);
      send_request(0, 0, 16384, 0);
      send_request(0, 0, -16384, 0);
      send_request(11585, 0, 0, 11585);            // north pole
      send_request(11585, 3000, 3000, 11585);
      send_request(11585, 0, 0, -11585);           // south pole
      send_request(-11585, 2000, -2000, 11585);
      send_request(16384, 0, 0, 16384);            // sine beyond one
      send_request(-16384, 0, 0, 16384);
      send_request(-32768, -32768, -32768, -32768); // out of range patterns
      send_request(32767, 32767, 32767, 32767);
      send_request(32767, -32768, 32767, -32768);
      send_request(8192, 8192, 8192, 8192);
      send_request(8192, -8192, 8192, -8192);
      end_stream();
   endtask

   task automatic test_threshold_sweep();
      set_threshold(16'd0);
      send_random_requests(250);
      set_threshold(16'd32768);
      send_random_requests(250);
      set_threshold(16'd65535);
      // no pole can fire here, so the sine saturates
      send_request(16384, 0, 0, 16384);
      send_request(-16384, 0, 0, 16384);
      send_random_requests(250);
   endtask

   task automatic test_ignored_register();
      drain_requests();
      csr_write(UNUSED_ADDR, 32'hFFFF_FFFF);
      csr_check_threshold();
   endtask

   task automatic test_random_threshold();
      set_threshold(16'($urandom_range(32600, 32767)));
      send_random_requests(300);
      set_threshold(16'($urandom));
      send_random_requests(150);
      // final stretch with no idling
      idle_enable = 1'b0;
      set_threshold(16'd32735);
      send_random_requests(300);
   endtask

   initial begin
      model_threshold = THRESH_RESET;
      idle_enable = 1'b1;
      mismatches = 0;
      stall_cycles = 0;
      accepted_now = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_threshold();
      test_directed();
      send_random_requests(400);
      test_threshold_sweep();
      test_ignored_register();
      test_random_threshold();
      drain_requests();
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
sv/q2e_pkg.sv
sv/q2e_front.sv
sv/q2e_queue.sv
sv/q2e_cordic.sv
sv/q2e_back.sv
sv/quaternion_to_euler_angles_top.sv
dv/tb_top.sv
